### rtl/torus_mesh_vertex_generator_assert.svh
// ----------------------------------------------------------------------------
// Torus mesh vertex generator assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TORUS_MESH_VERTEX_GENERATOR_ASSERT_SVH
`define TORUS_MESH_VERTEX_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define TMVG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TMVG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TMVG_ASSERT(lbl, prop, msg)
`define TMVG_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### rtl/tmvg_pkg.sv
// ----------------------------------------------------------------------------
// tmvg_pkg
// Types, constants and helpers shared by the torus mesh vertex generator.
// ----------------------------------------------------------------------------
package tmvg_pkg;

	localparam int MAX_SEGMENTS_DEF = 256;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [15:0] RING_RADIUS_RST   = 16'd256;
	localparam logic [15:0] TUBE_RADIUS_RST   = 16'd102;
	localparam logic [8:0]  RADIAL_COUNT_RST  = 9'd12;
	localparam logic [8:0]  TUBULAR_COUNT_RST = 9'd48;
	localparam logic [16:0] SWEEP_ARC_RST     = 17'd65536;
	localparam logic [16:0] FULL_TURN         = 17'd65536;

	typedef enum logic [2:0] {
		REG_RING_RADIUS   = 3'd0,
		REG_TUBE_RADIUS   = 3'd1,
		REG_RADIAL_COUNT  = 3'd2,
		REG_TUBULAR_COUNT = 3'd3,
		REG_SWEEP_ARC     = 3'd4
	} tmvg_reg_t;

	typedef struct packed {
		logic        has_quad;
		logic [16:0] corner_a;
		logic [16:0] corner_b;
	} tmvg_quad_t;

	typedef struct packed {
		logic [24:0] num_u;
		logic [24:0] num_t;
		logic [24:0] num_v;
		logic [8:0]  tub;
		logic [8:0]  rad;
		tmvg_quad_t  quad;
	} tmvg_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tmvg_qstat_t;

	typedef struct packed {
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		tmvg_quad_t  quad;
	} tmvg_tex_t;

	typedef struct packed {
		logic [3:0] neg;
		tmvg_tex_t  tex;
	} tmvg_sine_side_t;

	// a / 2^s, rounded half away from zero
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] a,
			input int unsigned s);
		logic [63:0] mag;
		logic [63:0] r;
		mag = a[63] ? 64'(-a) : 64'(a);
		r = (mag + (64'd1 << (s - 1))) >> s;
		return a[63] ? -$signed(r) : $signed(r);
	endfunction

endpackage

### rtl/tmvg_div.sv
// ----------------------------------------------------------------------------
// tmvg_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one valid and one sideband word.
// ----------------------------------------------------------------------------
module tmvg_div import tmvg_pkg::*; #(
	parameter int LANES  = 1,
	parameter int NUM_W  = 25,
	parameter int DEN_W  = 9,
	parameter int QUO_W  = 17,
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [LANES-1:0][NUM_W-1:0]       in_num,
	input  logic [LANES-1:0][DEN_W-1:0]       in_den,
	input  logic [SIDE_W-1:0]                 in_side,
	output logic                              out_valid,
	output logic [LANES-1:0][QUO_W-1:0]       out_quo,
	output logic [SIDE_W-1:0]                 out_side
);

	localparam int W = DEN_W + QUO_W;

	logic [QUO_W-1:0]                          valid_q;
	logic [QUO_W-1:0][LANES-1:0][W-1:0]        rem_q;
	logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]    den_q;
	logic [QUO_W-1:0][LANES-1:0][QUO_W-1:0]    quo_q;
	logic [QUO_W-1:0][SIDE_W-1:0]              side_q;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic                         vld_in;
		logic [LANES-1:0][W-1:0]      rem_in;
		logic [LANES-1:0][DEN_W-1:0]  den_in;
		logic [LANES-1:0][QUO_W-1:0]  quo_in;
		logic [SIDE_W-1:0]            side_in;
		logic [LANES-1:0][W-1:0]      shf;
		logic [LANES-1:0][W-1:0]      rem_nx;
		logic [LANES-1:0][QUO_W-1:0]  quo_nx;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = W'(in_num[l]);
				end
			end
			assign vld_in  = in_valid;
			assign den_in  = in_den;
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = valid_q[k-1];
			assign rem_in  = rem_q[k-1];
			assign den_in  = den_q[k-1];
			assign quo_in  = quo_q[k-1];
			assign side_in = side_q[k-1];
		end

		// subtract the shifted divisor where it fits
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				shf[l] = W'(den_in[l]) << (QUO_W - 1 - k);
				quo_nx[l] = quo_in[l];
				if (rem_in[l] >= shf[l]) begin
					rem_nx[l] = rem_in[l] - shf[l];
					quo_nx[l][QUO_W-1-k] = 1'b1;
				end else begin
					rem_nx[l] = rem_in[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[k] <= 1'b0;
			end else if (en) begin
				valid_q[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= rem_nx;
				den_q[k]  <= den_in;
				quo_q[k]  <= quo_nx;
				side_q[k] <= side_in;
			end
		end
	end

	assign out_valid = valid_q[QUO_W-1];
	assign out_quo   = quo_q[QUO_W-1];
	assign out_side  = side_q[QUO_W-1];

endmodule

### rtl/tmvg_front.sv
// ----------------------------------------------------------------------------
// tmvg_front
// Accepts grid points, clamps steps and counts, forms the divider
// numerators and the quad corner indices.
// ----------------------------------------------------------------------------
module tmvg_front import tmvg_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [8:0]  step_along,
	input  logic [8:0]  step_around,
	input  logic [8:0]  radial_count,
	input  logic [8:0]  tubular_count,
	input  logic [16:0] sweep_arc,
	input  tmvg_qstat_t qstat,
	output logic        push,
	output tmvg_item_t  item
);

	logic [8:0]  rad;
	logic [8:0]  tub;
	logic [16:0] arc;
	logic [8:0]  i_cl;
	logic [8:0]  j_cl;
	logic [25:0] prod_u;
	logic [9:0]  row_len;
	logic [18:0] row_base;
	logic [16:0] corner_a;

	always_comb begin
		if (radial_count == '0) begin
			rad = 9'd1;
		end else if (int'(radial_count) > MAX_SEGMENTS) begin
			rad = 9'(MAX_SEGMENTS);
		end else begin
			rad = radial_count;
		end
		if (tubular_count == '0) begin
			tub = 9'd1;
		end else if (int'(tubular_count) > MAX_SEGMENTS) begin
			tub = 9'(MAX_SEGMENTS);
		end else begin
			tub = tubular_count;
		end
		if (sweep_arc == '0) begin
			arc = 17'd1;
		end else if (sweep_arc > FULL_TURN) begin
			arc = FULL_TURN;
		end else begin
			arc = sweep_arc;
		end
	end

	assign i_cl = (step_along > tub) ? tub : step_along;
	assign j_cl = (step_around > rad) ? rad : step_around;

	assign prod_u   = i_cl * arc;
	assign row_len  = 10'(tub) + 10'd1;
	assign row_base = row_len * j_cl;
	assign corner_a = 17'(row_base + 19'(i_cl) - 19'd1);

	always_comb begin
		item.num_u = 25'(prod_u) + 25'(tub >> 1);
		item.num_t = {i_cl, 16'b0} + 25'(tub >> 1);
		item.num_v = {j_cl, 16'b0} + 25'(rad >> 1);
		item.tub   = tub;
		item.rad   = rad;
		if (i_cl != '0 && j_cl != '0) begin
			item.quad.has_quad = 1'b1;
			item.quad.corner_a = corner_a;
			item.quad.corner_b = corner_a - 17'(row_len);
		end else begin
			item.quad = '0;
		end
	end

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

endmodule

### rtl/tmvg_queue.sv
// ----------------------------------------------------------------------------
// tmvg_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module tmvg_queue import tmvg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tmvg_item_t  wr_item,
	input  logic        pop,
	output tmvg_item_t  head,
	output tmvg_qstat_t qstat
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	tmvg_item_t                   fifo_q [QUEUE_DEPTH];
	logic [PW-1:0]                wr_ptr_q;
	logic [PW-1:0]                rd_ptr_q;
	logic [PW:0]                  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= wr_item;
		end
	end

	assign head        = fifo_q[rd_ptr_q];
	assign qstat.full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

### rtl/tmvg_back.sv
// ----------------------------------------------------------------------------
// tmvg_back
// Phase division, sine/cosine evaluation, position and normal products and
// the output register.
// ----------------------------------------------------------------------------
module tmvg_back import tmvg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tmvg_item_t         head,
	input  tmvg_qstat_t        qstat,
	output logic               pop,
	input  logic [15:0]        ring_radius,
	input  logic [15:0]        tube_radius,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] pos_x,
	output logic signed [17:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               has_quad,
	output logic [16:0]        corner_upper,
	output logic [16:0]        corner_lower
);

	localparam int QW = $bits(tmvg_quad_t);
	localparam int SW = $bits(tmvg_sine_side_t);
	localparam logic [32:0] SINE_DEN_BASE = 33'd5 << 30;

	logic en;

	// phase dividers: uph, tex_u, vph
	logic [2:0][24:0] ph_num;
	logic [2:0][8:0]  ph_den;
	logic             ph_valid;
	logic [2:0][16:0] ph_quo;
	logic [QW-1:0]    ph_side;
	tmvg_quad_t       ph_quad;

	logic [3:0][15:0] phase;
	logic [3:0][30:0] qprod;
	logic             valid_s1;
	logic [3:0][28:0] q_s1;
	logic [3:0]       neg_s1;
	tmvg_tex_t        tex_s1;

	logic [3:0][46:0] sn_num;
	logic [3:0][32:0] sn_den;
	tmvg_sine_side_t  sn_side_in;
	logic             sn_valid;
	logic [3:0][14:0] sn_mag;
	logic [SW-1:0]    sn_side_raw;
	tmvg_sine_side_t  sn_side;

	logic signed [15:0] cu, su, cv, sv;
	logic signed [32:0] tcv;
	logic signed [32:0] tsv;
	logic signed [31:0] ncx, ncy;
	logic signed [63:0] pz_rnd, nx_rnd, ny_rnd;

	logic               valid_s2;
	logic signed [32:0] rho_s2;
	logic signed [15:0] cu_s2, su_s2;
	logic signed [16:0] pz_s2;
	logic signed [15:0] nx_s2, ny_s2, nz_s2;
	tmvg_tex_t          tex_s2;

	logic signed [63:0] px_rnd, py_rnd;

	logic               out_valid_q;
	logic signed [17:0] pos_x_q, pos_y_q;
	logic signed [16:0] pos_z_q;
	logic signed [15:0] norm_x_q, norm_y_q, norm_z_q;
	tmvg_tex_t          tex_q;

	// whole back end advances together; hold while the result waits
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !qstat.empty;

	assign ph_num[0] = head.num_u;
	assign ph_num[1] = head.num_t;
	assign ph_num[2] = head.num_v;
	assign ph_den[0] = head.tub;
	assign ph_den[1] = head.tub;
	assign ph_den[2] = head.rad;

	tmvg_div #(
		.LANES (3),
		.NUM_W (25),
		.DEN_W (9),
		.QUO_W (17),
		.SIDE_W(QW)
	) u_phase_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (!qstat.empty),
		.in_num   (ph_num),
		.in_den   (ph_den),
		.in_side  (head.quad),
		.out_valid(ph_valid),
		.out_quo  (ph_quo),
		.out_side (ph_side)
	);

	assign ph_quad = tmvg_quad_t'(ph_side);

	// cos = sin shifted a quarter turn
	assign phase[0] = ph_quo[0][15:0] + 16'd16384;
	assign phase[1] = ph_quo[0][15:0];
	assign phase[2] = ph_quo[2][15:0] + 16'd16384;
	assign phase[3] = ph_quo[2][15:0];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			qprod[l] = phase[l][14:0] * (16'd32768 - {1'b0, phase[l][14:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ph_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				q_s1[l]   <= qprod[l][28:0];
				neg_s1[l] <= phase[l][15];
			end
			tex_s1.tex_u <= ph_quo[1];
			tex_s1.tex_v <= ph_quo[2];
			tex_s1.quad  <= ph_quad;
		end
	end

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			sn_den[l] = SINE_DEN_BASE - {2'b0, q_s1[l], 2'b0};
			sn_num[l] = {q_s1[l], 18'b0} + 47'(sn_den[l] >> 1);
		end
	end

	assign sn_side_in.neg = neg_s1;
	assign sn_side_in.tex = tex_s1;

	tmvg_div #(
		.LANES (4),
		.NUM_W (47),
		.DEN_W (33),
		.QUO_W (15),
		.SIDE_W(SW)
	) u_sine_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.in_num   (sn_num),
		.in_den   (sn_den),
		.in_side  (sn_side_in),
		.out_valid(sn_valid),
		.out_quo  (sn_mag),
		.out_side (sn_side_raw)
	);

	assign sn_side = tmvg_sine_side_t'(sn_side_raw);

	assign cu = sn_side.neg[0] ? -$signed({1'b0, sn_mag[0]}) : $signed({1'b0, sn_mag[0]});
	assign su = sn_side.neg[1] ? -$signed({1'b0, sn_mag[1]}) : $signed({1'b0, sn_mag[1]});
	assign cv = sn_side.neg[2] ? -$signed({1'b0, sn_mag[2]}) : $signed({1'b0, sn_mag[2]});
	assign sv = sn_side.neg[3] ? -$signed({1'b0, sn_mag[3]}) : $signed({1'b0, sn_mag[3]});

	assign tcv    = $signed({1'b0, tube_radius}) * cv;
	assign tsv    = $signed({1'b0, tube_radius}) * sv;
	assign ncx    = cv * cu;
	assign ncy    = cv * su;
	assign pz_rnd = round_shift(64'(tsv), 14);
	assign nx_rnd = round_shift(64'(ncx), 14);
	assign ny_rnd = round_shift(64'(ncy), 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= sn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rho_s2 <= $signed({3'b0, ring_radius, 14'b0}) + tcv;
			cu_s2  <= cu;
			su_s2  <= su;
			pz_s2  <= pz_rnd[16:0];
			nx_s2  <= nx_rnd[15:0];
			ny_s2  <= ny_rnd[15:0];
			nz_s2  <= sv;
			tex_s2 <= sn_side.tex;
		end
	end

	assign px_rnd = round_shift(64'(rho_s2 * cu_s2), 28);
	assign py_rnd = round_shift(64'(rho_s2 * su_s2), 28);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_x_q  <= px_rnd[17:0];
			pos_y_q  <= py_rnd[17:0];
			pos_z_q  <= pz_s2;
			norm_x_q <= nx_s2;
			norm_y_q <= ny_s2;
			norm_z_q <= nz_s2;
			tex_q    <= tex_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign norm_x       = norm_x_q;
	assign norm_y       = norm_y_q;
	assign norm_z       = norm_z_q;
	assign tex_u        = tex_q.tex_u;
	assign tex_v        = tex_q.tex_v;
	assign has_quad     = tex_q.quad.has_quad;
	assign corner_upper = tex_q.quad.corner_a;
	assign corner_lower = tex_q.quad.corner_b;

endmodule

### rtl/torus_mesh_vertex_generator.sv
// ----------------------------------------------------------------------------
// torus_mesh_vertex_generator
// One grid point in, one torus vertex with normal, texture coordinates and
// quad corner indices out. Takes one point per clock while the input queue
// is not full. A point passes through the pipelined phase dividers, the
// pipelined sine dividers, and registers for the phase product, the
// radius/normal products and the output. The accepting edge itself writes
// the point into the four-entry input queue, from which the back end takes
// it when the back end is not held. A stall on the output freezes the
// back end while the queue keeps taking points until full.
// ----------------------------------------------------------------------------
`include "torus_mesh_vertex_generator_assert.svh"

module torus_mesh_vertex_generator import tmvg_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [8:0]         step_along,
	input  logic [8:0]         step_around,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] pos_x,
	output logic signed [17:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               has_quad,
	output logic [16:0]        corner_upper,
	output logic [16:0]        corner_lower
);

	logic [15:0] ring_radius_q;
	logic [15:0] tube_radius_q;
	logic [8:0]  radial_count_q;
	logic [8:0]  tubular_count_q;
	logic [16:0] sweep_arc_q;

	tmvg_qstat_t qstat;
	tmvg_item_t  wr_item;
	tmvg_item_t  head;
	logic        push;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_radius_q   <= RING_RADIUS_RST;
			tube_radius_q   <= TUBE_RADIUS_RST;
			radial_count_q  <= RADIAL_COUNT_RST;
			tubular_count_q <= TUBULAR_COUNT_RST;
			sweep_arc_q     <= SWEEP_ARC_RST;
		end else if (cfg_wen) begin
			case (tmvg_reg_t'(cfg_index))
				REG_RING_RADIUS:   ring_radius_q   <= cfg_data[15:0];
				REG_TUBE_RADIUS:   tube_radius_q   <= cfg_data[15:0];
				REG_RADIAL_COUNT:  radial_count_q  <= cfg_data[8:0];
				REG_TUBULAR_COUNT: tubular_count_q <= cfg_data[8:0];
				REG_SWEEP_ARC:     sweep_arc_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	tmvg_front #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.step_along   (step_along),
		.step_around  (step_around),
		.radial_count (radial_count_q),
		.tubular_count(tubular_count_q),
		.sweep_arc    (sweep_arc_q),
		.qstat        (qstat),
		.push         (push),
		.item         (wr_item)
	);

	tmvg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_item(wr_item),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	tmvg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.ring_radius (ring_radius_q),
		.tube_radius (tube_radius_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.norm_x      (norm_x),
		.norm_y      (norm_y),
		.norm_z      (norm_z),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.has_quad    (has_quad),
		.corner_upper(corner_upper),
		.corner_lower(corner_lower)
	);

	`TMVG_ASSERT(a_no_push_when_full, !(qstat.full && push), "push into full queue")
	`TMVG_ASSERT_IMPL(a_quad_tex, out_valid && has_quad, tex_u != '0 && tex_v != '0, "zero uv")
	`TMVG_ASSERT_IMPL(a_no_quad, out_valid && !has_quad, (corner_upper | corner_lower) == '0, "no quad")
	`TMVG_ASSERT_IMPL(a_nz_range, out_valid, norm_z <= 16'sd16384 && norm_z >= -16'sd16384, "norm_z")

endmodule
